[hw/rtl/ipnep_pkg.sv]
// ----------------------------------------------------------------------------
// ipnep_pkg
// Shared types, character codes and helper functions for the ipn endpoint
// text parser.
// ----------------------------------------------------------------------------
package ipnep_pkg;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned NUM_W = 64;

  // Character codes the parser reacts to.
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Lengths of the two literals: "none" in plain mode, "*.*" in pattern mode.
  localparam logic [2:0] LEN_NONE = 3'd4;
  localparam logic [2:0] LEN_STAR = 3'd3;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_NWS    = 10'b00_0000_0010,
    PH_NSIGN  = 10'b00_0000_0100,
    PH_NDIG   = 10'b00_0000_1000,
    PH_SSTART = 10'b00_0001_0000,
    PH_SWS    = 10'b00_0010_0000,
    PH_SSIGN  = 10'b00_0100_0000,
    PH_SDIG   = 10'b00_1000_0000,
    PH_SSTAR  = 10'b01_0000_0000,
    PH_BAD    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            empty_req;
    logic            pattern_mode;
  } item_t;

  // Unformatted result: the service number is still held as magnitude,
  // sign and saturation flag.
  typedef struct packed {
    logic             accepted;
    logic             node_any;
    logic             service_any;
    logic             num_sel;
    logic             ovf;
    logic             neg;
    logic [NUM_W-1:0] acc;
    logic [NUM_W-1:0] node;
  } raw_res_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [CH_W-1:0] lit_char(input logic mode, input logic [1:0] pos);
    logic [CH_W-1:0] c;
    c = 8'h00;
    if (mode) begin
      case (pos)
        2'd0:    c = CH_STAR;
        2'd1:    c = CH_DOT;
        2'd2:    c = CH_STAR;
        default: c = 8'h00;
      endcase
    end else begin
      case (pos)
        2'd0:    c = 8'h6E;  // 'n'
        2'd1:    c = 8'h6F;  // 'o'
        2'd2:    c = 8'h6E;  // 'n'
        default: c = 8'h65;  // 'e'
      endcase
    end
    return c;
  endfunction

endpackage

[hw/rtl/ipnep_digit.sv]
// ----------------------------------------------------------------------------
// ipnep_digit
// Decimal accumulate step: acc * 10 + digit with saturation detect.
// ----------------------------------------------------------------------------
module ipnep_digit
  import ipnep_pkg::*;
(
  input  logic [NUM_W-1:0] acc,
  input  logic             ovf,
  input  logic [CH_W-1:0]  ch,
  output logic [NUM_W-1:0] acc_nxt,
  output logic             ovf_nxt
);

  logic [3:0]       dig;
  logic [NUM_W+3:0] sum;

  assign dig = 4'(ch - CH_ZERO);
  // Times ten as (acc << 3) + (acc << 1); four guard bits catch the carry out.
  assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, dig};

  always_comb begin
    acc_nxt = acc;
    ovf_nxt = ovf;
    if (!ovf) begin
      if (sum[NUM_W+3:NUM_W] != 4'd0) begin
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = sum[NUM_W-1:0];
      end
    end
  end

endmodule

[hw/rtl/ipnep_parser.sv]
// ----------------------------------------------------------------------------
// ipnep_parser
// Per-character parse state, its update, and the raw result register.
// ----------------------------------------------------------------------------
module ipnep_parser
  import ipnep_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  item_t    item,
  output logic     item_ready,
  output logic     res_valid,
  output raw_res_t res,
  input  logic     res_ready
);

  phase_t           phase_r, phase_nxt;
  logic             mode_r, mode_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic             neg_r, neg_nxt;
  logic [NUM_W-1:0] node_r, node_nxt;
  logic [2:0]       lpos_r, lpos_nxt;
  logic             good_r, good_nxt;
  logic             res_valid_r;
  raw_res_t         res_r, res_nxt;

  // Starting state for this character: a new text starts from fresh values.
  phase_t           ph_c;
  logic             mode_c;
  logic [NUM_W-1:0] acc_c;
  logic             ovf_c;
  logic             neg_c;
  logic [NUM_W-1:0] node_c;
  logic [2:0]       lpos_c;
  logic             good_c;

  logic [NUM_W-1:0] dig_acc;
  logic             dig_ovf;
  logic [NUM_W-1:0] num_val;
  logic [2:0]       lit_len;
  logic             take;
  logic             final_item;
  logic             lit_hit;
  logic             c_dig;
  logic             c_sp;
  logic             c_sgn;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign final_item = item.last || item.empty_req;

  always_comb begin
    ph_c   = phase_r;
    mode_c = mode_r;
    acc_c  = acc_r;
    ovf_c  = ovf_r;
    neg_c  = neg_r;
    node_c = node_r;
    lpos_c = lpos_r;
    good_c = good_r;
    if (phase_r == PH_IDLE) begin
      ph_c   = PH_NWS;
      mode_c = item.pattern_mode;
      acc_c  = '0;
      ovf_c  = 1'b0;
      neg_c  = 1'b0;
      node_c = '0;
      lpos_c = 3'd0;
      good_c = 1'b1;
    end
  end

  ipnep_digit u_digit (
    .acc     (acc_c),
    .ovf     (ovf_c),
    .ch      (item.ch),
    .acc_nxt (dig_acc),
    .ovf_nxt (dig_ovf)
  );

  // Signed-and-saturated value of the node number, latched at the dot.
  assign num_val = ovf_c ? {NUM_W{1'b1}} : (neg_c ? (~acc_c + 1'b1) : acc_c);
  assign lit_len = mode_c ? LEN_STAR : LEN_NONE;
  assign c_dig   = is_digit(item.ch);
  assign c_sp    = is_space(item.ch);
  assign c_sgn   = (item.ch == CH_PLUS) || (item.ch == CH_MINUS);

  always_comb begin
    phase_nxt = ph_c;
    mode_nxt  = mode_c;
    acc_nxt   = acc_c;
    ovf_nxt   = ovf_c;
    neg_nxt   = neg_c;
    node_nxt  = node_c;
    lpos_nxt  = lpos_c;
    good_nxt  = good_c;
    if (!item.empty_req) begin
      if (good_c) begin
        if ((lpos_c < lit_len) && (item.ch == lit_char(mode_c, lpos_c[1:0]))) begin
          lpos_nxt = lpos_c + 3'd1;
        end else begin
          good_nxt = 1'b0;
        end
      end
      case (ph_c)
        PH_NWS, PH_SWS: begin
          if (c_dig) begin
            acc_nxt   = dig_acc;
            ovf_nxt   = dig_ovf;
            phase_nxt = (ph_c == PH_NWS) ? PH_NDIG : PH_SDIG;
          end else if (c_sp) begin
            phase_nxt = ph_c;
          end else if (c_sgn) begin
            neg_nxt   = (item.ch == CH_MINUS);
            phase_nxt = (ph_c == PH_NWS) ? PH_NSIGN : PH_SSIGN;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_NSIGN, PH_SSIGN: begin
          if (c_dig) begin
            acc_nxt   = dig_acc;
            ovf_nxt   = dig_ovf;
            phase_nxt = (ph_c == PH_NSIGN) ? PH_NDIG : PH_SDIG;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_NDIG: begin
          if (c_dig) begin
            acc_nxt = dig_acc;
            ovf_nxt = dig_ovf;
          end else if (item.ch == CH_DOT) begin
            node_nxt  = num_val;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
            neg_nxt   = 1'b0;
            phase_nxt = PH_SSTART;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_SSTART: begin
          if (item.ch == CH_STAR) begin
            phase_nxt = mode_c ? PH_SSTAR : PH_BAD;
          end else if (c_dig) begin
            acc_nxt   = dig_acc;
            ovf_nxt   = dig_ovf;
            phase_nxt = PH_SDIG;
          end else if (c_sp) begin
            phase_nxt = PH_SWS;
          end else if (c_sgn) begin
            neg_nxt   = (item.ch == CH_MINUS);
            phase_nxt = PH_SSIGN;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_SDIG: begin
          if (c_dig) begin
            acc_nxt = dig_acc;
            ovf_nxt = dig_ovf;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        default: begin
          phase_nxt = PH_BAD;
        end
      endcase
    end
  end

  // Verdict on the text as it stands after this character.
  assign lit_hit = good_nxt && (mode_c ? ((lpos_nxt == 3'd1) || (lpos_nxt == 3'd3))
                                       : (lpos_nxt == LEN_NONE));

  always_comb begin
    res_nxt = '0;
    if (lit_hit) begin
      res_nxt.accepted    = 1'b1;
      res_nxt.node_any    = mode_c;
      res_nxt.service_any = mode_c;
    end else if (phase_nxt == PH_SDIG) begin
      res_nxt.accepted = 1'b1;
      res_nxt.node     = node_nxt;
      res_nxt.num_sel  = 1'b1;
      res_nxt.acc      = acc_nxt;
      res_nxt.ovf      = ovf_nxt;
      res_nxt.neg      = neg_nxt;
    end else if ((phase_nxt == PH_SSTAR) && mode_c) begin
      res_nxt.accepted    = 1'b1;
      res_nxt.node        = node_nxt;
      res_nxt.service_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= final_item ? PH_IDLE : phase_nxt;
      end
      if (take && final_item) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      neg_r  <= neg_nxt;
      node_r <= node_nxt;
      lpos_r <= lpos_nxt;
      good_r <= good_nxt;
      if (final_item) begin
        res_r <= res_nxt;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[hw/rtl/ipnep_out.sv]
// ----------------------------------------------------------------------------
// ipnep_out
// Applies sign and saturation to the service number and holds the result beat.
// ----------------------------------------------------------------------------
module ipnep_out
  import ipnep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  raw_res_t           res,
  output logic               res_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2*NUM_W-1:0] out_tdata,
  output logic [2:0]         out_tuser
);

  logic               out_tvalid_r;
  logic [2*NUM_W-1:0] out_tdata_r;
  logic [2:0]         out_tuser_r;
  logic [NUM_W-1:0]   service;

  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    service = '0;
    if (res.num_sel) begin
      service = res.ovf ? {NUM_W{1'b1}} : (res.neg ? (~res.acc + 1'b1) : res.acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= {service, res.node};
      out_tuser_r <= {res.service_any, res.node_any, res.accepted};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[hw/rtl/ipn_endpoint_text_parser.sv]
// ----------------------------------------------------------------------------
// ipn_endpoint_text_parser
// Streaming parser for the text that follows "ipn:" in an endpoint identifier.
// ----------------------------------------------------------------------------
// The block takes the text one character per input beat and returns one
// result beat per text, on the beat marked tlast (or carrying an empty
// request). A new character is accepted every clock cycle while no result
// waits on a stalled output; the rate is set by the parse state loop, where
// each character does one decimal multiply-by-ten accumulate (shift-and-add)
// with a saturation check. A result beat passes from the input register,
// which loads its final character, through the parse stage's result
// register to the output stage, which applies the sign to the service
// number. While a result waits on a stalled output, the parse stage holds
// off further characters. In plain mode the text "none" or "node.service"
// is accepted; in pattern mode "*", "*.*", "node.*" or "node.service".
// Numbers read like a base-10 strtoull: leading whitespace, an optional
// sign, at least one digit, a minus that wraps modulo 2^64 and saturation
// at 2^64-1. A rejected text returns all zeros. The pattern_mode flag is
// sampled on the first beat of each text.
// ----------------------------------------------------------------------------
module ipn_endpoint_text_parser
  import ipnep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input characters.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [CH_W-1:0]    in_tdata,   // [7:0] ch
  input  logic               in_tlast,   // last character of the text
  input  logic [1:0]         in_tuser,   // [0] empty_req, [1] pattern_mode
  // Parse results.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2*NUM_W-1:0] out_tdata,  // [63:0] node, [127:64] service
  output logic [2:0]         out_tuser   // [0] accepted, [1] node_any, [2] service_any
);

  // Input register: decouples the upstream handshake from the parse logic.
  logic     in_valid_r;
  item_t    item_r;
  logic     par_ready;
  logic     res_valid;
  raw_res_t res;
  logic     res_ready;

  // A bubble in the input register is refilled even while the parser stalls.
  assign in_tready = !in_valid_r || par_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.ch           <= in_tdata;
      item_r.last         <= in_tlast;
      item_r.empty_req    <= in_tuser[0];
      item_r.pattern_mode <= in_tuser[1];
    end
  end

  // Parse stage: one character per cycle into the running state while no held
  // result is stalled; the final character also loads the raw result register.
  ipnep_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (item_r),
    .item_ready (par_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output stage: final service value and the output register.
  ipnep_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[hw/rtl/ipnep_checker.sv]
// ----------------------------------------------------------------------------
// ipnep_checker
// Port-level checks on the result stream of the ipn endpoint text parser.
// ----------------------------------------------------------------------------
module ipnep_checker
  import ipnep_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [2*NUM_W-1:0] out_tdata,
  input logic [2:0]         out_tuser
);

  // A result that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A rejected text carries no numbers and no wildcard flags.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && out_tuser == 3'b000)
    else $error("rejected result is not all zero");

  // A node wildcard only comes from the full wildcard patterns "*" and "*.*".
  a_node_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && out_tuser[2] && out_tdata == '0)
    else $error("node wildcard without full wildcard result");

  // A service wildcard reads service zero and is always accepted.
  a_service_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0] && out_tdata[2*NUM_W-1:NUM_W] == '0)
    else $error("service wildcard with nonzero service");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind ipn_endpoint_text_parser ipnep_checker u_ipnep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
